// ===== rtl/core/flps_pkg.sv =====
package flps_pkg;

    // Width of the grid_size configuration register.
    localparam int CFG_W = 11;

    // Row and column fields of a result are always this wide.
    localparam int POS_OUT_W = 10;

    // Grid side length after reset, before it is limited to MAX_SIDE.
    localparam int GRID_RESET = 1024;

    // Result growth over the sample: four times the centre plus four terms.
    localparam int EXTRA_BITS = 3;

    // Most results one sample can cause (the final sample of a frame).
    localparam int MAX_RESULTS = 3;

    // Result queue between the stencil and the output port.
    localparam int QUEUE_DEPTH = 8;
    localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
    localparam int QPTR_W      = QADDR_W + 1;

endpackage

// ===== rtl/core/flps_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// A read of the address being written in the same cycle returns the old data.
module flps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/five_point_laplacian_stencil.sv =====
// Five-point Laplacian over an N-by-N grid streamed in raster order, one signed
// fixed-point sample per beat. Each result is 4*centre minus its four neighbours,
// with neighbours outside the grid taken as zero; the arithmetic is exact and the
// result is three bits wider than the sample. The result for (i-1,j) leaves when
// sample (i,j) is taken, so row 0 gives nothing by itself; in the last row each
// sample also gives the result for its left neighbour, and the final sample of a
// frame gives (N-1,N-1) as well. A frame_start flag in tuser forces the sample to
// position (0,0); the position also wraps after N*N samples, and a write to the
// configuration channel (grid_size, limited to 2..MAX_SIDE) returns it to (0,0).
// Configuration must only be written while the block is idle. Throughput is one
// sample per cycle outside the last row while the result queue has room; in the
// last row each sample gives two results and the output port moves one result
// per cycle, so the last row runs slower. The output port is the limit: the
// line stores are read and written once per sample. The first result of a sample
// is registered in stage 1 and then written into the result queue, from which
// it is offered. The two line stores are synchronous RAMs of MAX_SIDE words;
// the newest row is kept in two copies so that the centre and right neighbour
// can be read in the same cycle. The stores need no clearing pass: the stencil
// only reads entries written earlier in the same frame.
module five_point_laplacian_stencil #(
    parameter int MAX_SIDE    = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,

    // Sample stream in.
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata fields from bit 0: sample.
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  s_axis_tdata,
    // tuser fields from bit 0: frame_start.
    input  logic [0:0]                                s_axis_tuser,

    // Result stream out; tlast is end_of_run.
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // tdata fields from bit 0: value, row, col, zero padding.
    output logic [((SAMPLE_BITS + flps_pkg::EXTRA_BITS + 2 * flps_pkg::POS_OUT_W
                    + 7) / 8) * 8 - 1:0]             m_axis_tdata,
    output logic                                      m_axis_tlast,
    // tuser fields from bit 0: end_of_frame.
    output logic [0:0]                                m_axis_tuser,

    // grid_size write channel.
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [flps_pkg::CFG_W-1:0]                i_cfg_data
);

    localparam int POS_W = $clog2(MAX_SIDE);
    localparam int VW    = SAMPLE_BITS + flps_pkg::EXTRA_BITS;
    localparam int OUT_W = ((VW + 2 * flps_pkg::POS_OUT_W + 7) / 8) * 8;
    localparam int QA    = flps_pkg::QADDR_W;
    localparam int QP    = flps_pkg::QPTR_W;

    // The reset grid size, already limited to what the stores can hold.
    localparam int RESET_SIDE = (MAX_SIDE < flps_pkg::GRID_RESET) ? MAX_SIDE
                                                                   : flps_pkg::GRID_RESET;

    localparam logic signed [VW-1:0] ZERO_V = '0;

    typedef struct packed {
        logic                               eof;
        logic                               eor;
        logic [flps_pkg::POS_OUT_W-1:0]     col;
        logic [flps_pkg::POS_OUT_W-1:0]     row;
        logic signed [VW-1:0]               value;
    } t_result;

    // ------------------------------------------------------------------
    // Configuration and position counters
    // ------------------------------------------------------------------
    // r_last holds N-1, so every position compare is against it directly.
    logic [POS_W-1:0] r_last, n_last;
    logic [POS_W-1:0] r_row, n_row;
    logic [POS_W-1:0] r_col, n_col;

    logic             cfg_acc;
    logic             acc;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_last = r_last;
        if (cfg_acc) begin
            priority if (i_cfg_data < flps_pkg::CFG_W'(2)) begin
                n_last = POS_W'(1);
            end else if (32'(i_cfg_data) > MAX_SIDE) begin
                n_last = POS_W'(MAX_SIDE - 1);
            end else begin
                n_last = POS_W'(i_cfg_data - flps_pkg::CFG_W'(1));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: resolve the position of the offered sample, read the stores
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          in_frame_start;
    logic [POS_W-1:0]              pos_row;
    logic [POS_W-1:0]              pos_col;
    logic                          at_last_row;
    logic                          at_last_col;
    logic                          has_up0;
    logic                          has_last0;
    logic                          has_fin0;
    logic [1:0]                    k0;
    logic [POS_W-1:0]              addr_b;

    assign in_sample      = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
    assign in_frame_start = s_axis_tuser[0];

    always_comb begin
        pos_row     = in_frame_start ? '0 : r_row;
        pos_col     = in_frame_start ? '0 : r_col;
        at_last_row = (pos_row == r_last);
        at_last_col = (pos_col == r_last);
        // Result counts: the row above is finished from row 1 on; the last row
        // also finishes its own samples, and the final one finishes itself.
        has_up0     = (pos_row != '0);
        has_last0   = at_last_row && (pos_col != '0);
        has_fin0    = at_last_row && at_last_col;
        k0          = {1'b0, has_up0} + {1'b0, has_last0} + {1'b0, has_fin0};
        // The right neighbour does not exist in the last column; keep the
        // address in range there, the data is not used.
        addr_b      = at_last_col ? pos_col : pos_col + POS_W'(1);
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        priority if (cfg_acc) begin
            n_row = '0;
            n_col = '0;
        end else if (acc) begin
            if (at_last_col) begin
                n_col = '0;
                n_row = at_last_row ? '0 : pos_row + POS_W'(1);
            end else begin
                n_col = pos_col + POS_W'(1);
                n_row = pos_row;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 registers
    // ------------------------------------------------------------------
    logic                          r1_valid;
    logic [POS_W-1:0]              r1_row;
    logic [POS_W-1:0]              r1_col;
    logic signed [SAMPLE_BITS-1:0] r1_s;
    logic [1:0]                    r1_k;
    logic                          r1_has_last;
    logic                          r1_has_fin;
    logic                          r1_left;
    logic                          r1_left2;
    logic                          r1_right;
    logic                          r1_up2;

    // Values of recent samples and of the row above, kept in flops so that the
    // stores need only one read address each per sample. Consecutive beats in
    // one row are always consecutive columns, so these line up by column.
    logic signed [SAMPLE_BITS-1:0] r_s_d1;     // row i, column j-1
    logic signed [SAMPLE_BITS-1:0] r_s_d2;     // row i, column j-2
    logic signed [SAMPLE_BITS-1:0] r_up_left;  // row i-1, column j-1

    // Store write-to-read forwarding.
    logic                          r_fwd_pa;
    logic                          r_fwd_pb;
    logic                          r_fwd_ol;
    logic signed [SAMPLE_BITS-1:0] r_fwd_s;
    logic signed [SAMPLE_BITS-1:0] r_fwd_old;

    logic [SAMPLE_BITS-1:0]        pa_q;
    logic [SAMPLE_BITS-1:0]        pb_q;
    logic [SAMPLE_BITS-1:0]        ol_q;
    logic signed [SAMPLE_BITS-1:0] pa_d;
    logic signed [SAMPLE_BITS-1:0] pb_d;
    logic signed [SAMPLE_BITS-1:0] ol_d;

    // ------------------------------------------------------------------
    // Line stores. The newest row is written by stage 1 with the sample, and
    // the row it replaces moves into the older row store at the same column.
    // ------------------------------------------------------------------
    flps_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SIDE)
    ) u_prev_centre (
        .i_clk   (i_clk),
        .i_we    (r1_valid),
        .i_waddr (r1_col),
        .i_wdata (r1_s),
        .i_raddr (pos_col),
        .o_rdata (pa_q)
    );

    flps_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SIDE)
    ) u_prev_right (
        .i_clk   (i_clk),
        .i_we    (r1_valid),
        .i_waddr (r1_col),
        .i_wdata (r1_s),
        .i_raddr (addr_b),
        .o_rdata (pb_q)
    );

    flps_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SIDE)
    ) u_older (
        .i_clk   (i_clk),
        .i_we    (r1_valid),
        .i_waddr (r1_col),
        .i_wdata (pa_d),
        .i_raddr (pos_col),
        .o_rdata (ol_q)
    );

    // A read that met the stage 1 write of the same column returned the old
    // word; take the word that was written instead. With N=2 this happens at
    // every row change, where the right neighbour is the sample just taken.
    assign pa_d = r_fwd_pa ? r_fwd_s   : $signed(pa_q);
    assign pb_d = r_fwd_pb ? r_fwd_s   : $signed(pb_q);
    assign ol_d = r_fwd_ol ? r_fwd_old : $signed(ol_q);

    // ------------------------------------------------------------------
    // Stage 1: the three possible results of one sample
    // ------------------------------------------------------------------
    logic signed [VW-1:0] s_x;
    logic signed [VW-1:0] pa_x;
    logic signed [VW-1:0] pb_x;
    logic signed [VW-1:0] ol_x;
    logic signed [VW-1:0] d1_x;
    logic signed [VW-1:0] d2_x;
    logic signed [VW-1:0] ul_x;
    t_result              res_up;
    t_result              res_last;
    t_result              res_fin;

    always_comb begin
        s_x  = VW'(r1_s);
        pa_x = VW'(pa_d);
        pb_x = VW'(pb_d);
        ol_x = VW'(ol_d);
        d1_x = VW'(r_s_d1);
        d2_x = VW'(r_s_d2);
        ul_x = VW'(r_up_left);

        // Result for the row above: the sample taken now is its lower neighbour.
        res_up.value = (pa_x <<< 2)
                     - (r1_left  ? ul_x : ZERO_V)
                     - (r1_right ? pb_x : ZERO_V)
                     - (r1_up2   ? ol_x : ZERO_V)
                     - s_x;
        res_up.row   = flps_pkg::POS_OUT_W'(r1_row - POS_W'(1));
        res_up.col   = flps_pkg::POS_OUT_W'(r1_col);
        res_up.eor   = !r1_has_last;
        res_up.eof   = 1'b0;

        // Last row, left neighbour of the sample: nothing lies below it.
        res_last.value = (d1_x <<< 2)
                       - (r1_left2 ? d2_x : ZERO_V)
                       - s_x
                       - ul_x;
        res_last.row   = flps_pkg::POS_OUT_W'(r1_row);
        res_last.col   = flps_pkg::POS_OUT_W'(r1_col - POS_W'(1));
        res_last.eor   = !r1_has_fin;
        res_last.eof   = 1'b0;

        // Bottom right corner: only the left and upper neighbours exist.
        res_fin.value = (s_x <<< 2) - d1_x - pa_x;
        res_fin.row   = flps_pkg::POS_OUT_W'(r1_row);
        res_fin.col   = flps_pkg::POS_OUT_W'(r1_col);
        res_fin.eor   = 1'b1;
        res_fin.eof   = 1'b1;
    end

    // ------------------------------------------------------------------
    // Result queue. A sample is taken only while the queue, counting results
    // still in stage 1, has room for the most one sample can cause, so stage 1
    // never waits. Results of one sample always come as a prefix of
    // (row above, last row, corner), so they go in at consecutive slots.
    // ------------------------------------------------------------------
    t_result          r_queue [flps_pkg::QUEUE_DEPTH];
    logic [QP-1:0]    r_wr, n_wr;
    logic [QP-1:0]    r_rd, n_rd;
    logic [QP-1:0]    r_used, n_used;
    logic [QA-1:0]    wa0;
    logic [QA-1:0]    wa1;
    logic [QA-1:0]    wa2;
    logic             pop;
    t_result          head;

    assign s_axis_tready = (r_used <= QP'(flps_pkg::QUEUE_DEPTH - flps_pkg::MAX_RESULTS));
    assign acc           = s_axis_tvalid && s_axis_tready;

    assign wa0 = r_wr[QA-1:0];
    assign wa1 = wa0 + QA'(1);
    assign wa2 = wa0 + QA'(2);

    assign head          = r_queue[r_rd[QA-1:0]];
    assign m_axis_tvalid = (r_wr != r_rd);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = OUT_W'({head.col, head.row, head.value});
    assign m_axis_tlast  = head.eor;
    assign m_axis_tuser  = head.eof;

    always_comb begin
        n_wr   = r_wr + (r1_valid ? QP'(r1_k) : '0);
        n_rd   = r_rd + QP'(pop);
        n_used = r_used + (acc ? QP'(k0) : '0) - QP'(pop);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= POS_W'(RESET_SIDE - 1);
            r_row    <= '0;
            r_col    <= '0;
            r1_valid <= 1'b0;
            r_fwd_pa <= 1'b0;
            r_fwd_pb <= 1'b0;
            r_fwd_ol <= 1'b0;
            r_wr     <= '0;
            r_rd     <= '0;
            r_used   <= '0;
        end else begin
            r_last   <= n_last;
            r_row    <= n_row;
            r_col    <= n_col;
            r1_valid <= acc;
            r_fwd_pa <= r1_valid && (pos_col == r1_col);
            r_fwd_pb <= r1_valid && (addr_b == r1_col);
            r_fwd_ol <= r1_valid && (pos_col == r1_col);
            r_wr     <= n_wr;
            r_rd     <= n_rd;
            r_used   <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r1_row      <= pos_row;
            r1_col      <= pos_col;
            r1_s        <= in_sample;
            r1_k        <= k0;
            r1_has_last <= has_last0;
            r1_has_fin  <= has_fin0;
            r1_left     <= (pos_col != '0);
            r1_left2    <= (pos_col > POS_W'(1));
            r1_right    <= !at_last_col;
            r1_up2      <= (pos_row > POS_W'(1));
        end
        if (r1_valid) begin
            r_s_d1    <= r1_s;
            r_s_d2    <= r_s_d1;
            r_up_left <= pa_d;
            if (r1_k != 2'd0) begin
                r_queue[wa0] <= res_up;
            end
            if (r1_k > 2'd1) begin
                r_queue[wa1] <= res_last;
            end
            if (r1_k > 2'd2) begin
                r_queue[wa2] <= res_fin;
            end
        end
        r_fwd_s   <= r1_s;
        r_fwd_old <= pa_d;
    end

endmodule

// ===== rtl/core/flps_chk.sv =====
// Port-level checks for the stencil block.
module flps_chk #(
    parameter int SAMPLE_BITS = 32
) (
    input logic                                      i_clk,
    input logic                                      i_rst_n,
    input logic                                      m_axis_tvalid,
    input logic                                      m_axis_tready,
    input logic [((SAMPLE_BITS + flps_pkg::EXTRA_BITS + 2 * flps_pkg::POS_OUT_W
                   + 7) / 8) * 8 - 1:0]              m_axis_tdata,
    input logic                                      m_axis_tlast,
    input logic [0:0]                                m_axis_tuser
);

    localparam int VW = SAMPLE_BITS + flps_pkg::EXTRA_BITS;
    localparam int PW = flps_pkg::POS_OUT_W;

    // Nothing is offered right after reset: the queue starts empty.
    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result offered right after reset");

    // The corner result is always the last one its sample causes.
    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("end of frame without end of run");

    // The corner result lies on the diagonal.
    a_eof_on_diagonal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0])
            |-> (m_axis_tdata[VW +: PW] == m_axis_tdata[VW + PW +: PW]))
        else $error("end of frame off the diagonal");

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
                 && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind five_point_laplacian_stencil flps_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_flps_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
